### design/qat_pkg.sv
`default_nettype none

package qat_pkg;

    localparam int CHAR_W = 21;
    localparam int QAT_FIFO_DEPTH = 4;

    localparam logic [CHAR_W-1:0] CH_SPACE  = CHAR_W'(32);
    localparam logic [CHAR_W-1:0] CH_QUOTE  = CHAR_W'(34);
    localparam logic [CHAR_W-1:0] CH_APOS   = CHAR_W'(39);
    localparam logic [CHAR_W-1:0] CH_BSLASH = CHAR_W'(92);

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_STAT = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MISPLACED = 2'd1;
    localparam logic [1:0] ST_UNTERM    = 2'd2;

    typedef enum logic [1:0] {
        PH_NORMAL,
        PH_ESCAPE,
        PH_CLOSE
    } t_phase;

    // results caused by one character, always delivered in the order char, end, status
    typedef struct packed {
        logic              has_char;
        logic [CHAR_W-1:0] ch;
        logic              has_end;
        logic              has_stat;
        logic [1:0]        stat;
    } t_bundle;

endpackage

`default_nettype wire

### design/quoted_argument_tokenizer_core.sv
// Channel   Direction  Handshake          Payload
// input     in         i_push / o_full    i_char_code, i_line_end
// result    out        o_empty / i_pop    o_event_kind, o_out_char, o_line_status,
//                                         o_last_of_run
//
// One character is accepted per cycle while the result queue has room.
// Results leave one per cycle while i_pop is held; the output port sets the
// sustained rate, so the results of one character leave one by one, one per pop.
// A character's first result goes through the queue and output register to the ports.
// Synchronous active-low reset empties the queue and returns to line start.
// A stalled result side fills the queue and then raises o_full.
`default_nettype none

module quoted_argument_tokenizer_core #(
    parameter int FIFO_DEPTH = qat_pkg::QAT_FIFO_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    output logic                            o_full,
    input  wire logic [qat_pkg::CHAR_W-1:0] i_char_code,
    input  wire logic                       i_line_end,
    input  wire logic                       i_pop,
    output logic                            o_empty,
    output logic [1:0]                      o_event_kind,
    output logic [qat_pkg::CHAR_W-1:0]      o_out_char,
    output logic [1:0]                      o_line_status,
    output logic                            o_last_of_run
);
    import qat_pkg::*;

    t_bundle wr_bundle, rd_bundle;
    logic    wr, rd, q_empty;

    qat_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_char_code (i_char_code),
        .i_line_end  (i_line_end),
        .i_full      (o_full),
        .o_wr        (wr),
        .o_bundle    (wr_bundle)
    );

    qat_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_wdata (wr_bundle),
        .i_rd    (rd),
        .o_rdata (rd_bundle),
        .o_full  (o_full),
        .o_empty (q_empty)
    );

    qat_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bundle      (rd_bundle),
        .i_q_empty     (q_empty),
        .o_q_rd        (rd),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_event_kind  (o_event_kind),
        .o_out_char    (o_out_char),
        .o_line_status (o_line_status),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

### design/qat_front.sv
`default_nettype none

module qat_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    input  wire logic [qat_pkg::CHAR_W-1:0] i_char_code,
    input  wire logic                      i_line_end,
    input  wire logic                      i_full,
    output logic                           o_wr,
    output qat_pkg::t_bundle               o_bundle
);
    import qat_pkg::*;

    t_phase r_phase, n_phase;
    logic   r_inside, n_inside;
    logic   r_prev_sp, n_prev_sp;
    logic   r_tok_ne, n_tok_ne;
    logic   r_last_sp, n_last_sp;
    logic   r_err_skip, n_err_skip;

    logic    accept;
    logic    is_sp, is_q, is_bs, is_ap;
    logic    err;
    t_bundle b;

    assign accept = i_push && !i_full;
    assign is_sp  = (i_char_code == CH_SPACE);
    assign is_q   = (i_char_code == CH_QUOTE);
    assign is_bs  = (i_char_code == CH_BSLASH);
    assign is_ap  = (i_char_code == CH_APOS);

    always_comb begin
        n_phase    = r_phase;
        n_inside   = r_inside;
        n_prev_sp  = r_prev_sp;
        n_tok_ne   = r_tok_ne;
        n_last_sp  = r_last_sp;
        n_err_skip = r_err_skip;
        err        = 1'b0;
        b          = '0;
        b.ch       = i_char_code;

        if (r_err_skip) begin
            if (i_line_end) begin
                n_err_skip = 1'b0;
                n_phase    = PH_NORMAL;
                n_inside   = 1'b0;
                n_prev_sp  = 1'b1;
                n_tok_ne   = 1'b0;
                n_last_sp  = 1'b0;
            end
        end else begin
            unique case (r_phase)
                PH_ESCAPE: begin
                    if (is_bs || is_q || is_ap) begin
                        b.has_char = 1'b1;
                        n_tok_ne   = 1'b1;
                        n_last_sp  = 1'b0;
                    end
                    n_phase = PH_NORMAL;
                end
                PH_CLOSE: begin
                    if (!is_sp) begin
                        err = 1'b1;
                    end else begin
                        b.has_end = 1'b1;
                        n_tok_ne  = 1'b0;
                        n_last_sp = 1'b0;
                        n_phase   = PH_NORMAL;
                    end
                end
                default: begin
                    if (is_bs) begin
                        if (!i_line_end) n_phase = PH_ESCAPE;
                    end else if (is_q) begin
                        if (r_inside) begin
                            n_inside = 1'b0;
                            if (i_line_end) begin
                                b.has_end = 1'b1;
                                n_tok_ne  = 1'b0;
                                n_last_sp = 1'b0;
                            end else begin
                                n_phase = PH_CLOSE;
                            end
                        end else if (!r_prev_sp) begin
                            err = 1'b1;
                        end else begin
                            n_inside = 1'b1;
                        end
                    end else if (is_sp) begin
                        if (r_inside) begin
                            // collapse runs of spaces inside quotes
                            if (!r_last_sp) begin
                                b.has_char = 1'b1;
                                n_tok_ne   = 1'b1;
                                n_last_sp  = 1'b1;
                            end
                        end else begin
                            b.has_end = 1'b1;
                            n_tok_ne  = 1'b0;
                            n_last_sp = 1'b0;
                        end
                    end else begin
                        b.has_char = 1'b1;
                        n_tok_ne   = 1'b1;
                        n_last_sp  = 1'b0;
                    end
                end
            endcase

            if (err) begin
                b          = '0;
                b.ch       = i_char_code;
                b.has_stat = 1'b1;
                b.stat     = ST_MISPLACED;
                n_phase    = r_phase;
                n_inside   = r_inside;
                n_tok_ne   = r_tok_ne;
                n_last_sp  = r_last_sp;
                if (i_line_end) begin
                    n_phase   = PH_NORMAL;
                    n_inside  = 1'b0;
                    n_prev_sp = 1'b1;
                    n_tok_ne  = 1'b0;
                    n_last_sp = 1'b0;
                end else begin
                    n_err_skip = 1'b1;
                end
            end else begin
                n_prev_sp = is_sp;
                if (i_line_end) begin
                    b.has_stat = 1'b1;
                    b.stat     = n_inside ? ST_UNTERM : ST_OK;
                    if (n_tok_ne || n_inside) b.has_end = 1'b1;
                    n_phase   = PH_NORMAL;
                    n_inside  = 1'b0;
                    n_prev_sp = 1'b1;
                    n_tok_ne  = 1'b0;
                    n_last_sp = 1'b0;
                end
            end
        end
    end

    assign o_bundle = b;
    assign o_wr     = accept && (b.has_char || b.has_end || b.has_stat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_NORMAL;
            r_inside   <= 1'b0;
            r_prev_sp  <= 1'b1;
            r_tok_ne   <= 1'b0;
            r_last_sp  <= 1'b0;
            r_err_skip <= 1'b0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_inside   <= n_inside;
            r_prev_sp  <= n_prev_sp;
            r_tok_ne   <= n_tok_ne;
            r_last_sp  <= n_last_sp;
            r_err_skip <= n_err_skip;
        end
    end

endmodule

`default_nettype wire

### design/qat_fifo.sv
`default_nettype none

module qat_fifo #(
    parameter int DEPTH = qat_pkg::QAT_FIFO_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  qat_pkg::t_bundle      i_wdata,
    input  wire logic             i_rd,
    output qat_pkg::t_bundle      o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);
    import qat_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_bundle r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_wr, do_rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) r_mem[r_wptr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_wr) r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            if (do_rd) r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            if (do_wr && !do_rd)      r_cnt <= r_cnt + 1'b1;
            else if (do_rd && !do_wr) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

`default_nettype wire

### design/qat_back.sv
`default_nettype none

module qat_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  qat_pkg::t_bundle                i_bundle,
    input  wire logic                       i_q_empty,
    output logic                            o_q_rd,
    input  wire logic                       i_pop,
    output logic                            o_empty,
    output logic [1:0]                      o_event_kind,
    output logic [qat_pkg::CHAR_W-1:0]      o_out_char,
    output logic [1:0]                      o_line_status,
    output logic                            o_last_of_run
);
    import qat_pkg::*;

    logic              r_rc, r_re, r_rs;
    logic              n_rc, n_re, n_rs;
    logic [CHAR_W-1:0] r_ch;
    logic [1:0]        r_stat;
    logic              take, load;

    assign o_empty = !(r_rc || r_re || r_rs);
    assign take    = i_pop && !o_empty;

    always_comb begin
        n_rc = r_rc;
        n_re = r_re;
        n_rs = r_rs;
        // drop the result just transferred
        if (take) begin
            priority if (r_rc) n_rc = 1'b0;
            else if (r_re)     n_re = 1'b0;
            else               n_rs = 1'b0;
        end
        load = !(n_rc || n_re || n_rs) && !i_q_empty;
        if (load) begin
            n_rc = i_bundle.has_char;
            n_re = i_bundle.has_end;
            n_rs = i_bundle.has_stat;
        end
    end

    assign o_q_rd = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc <= 1'b0;
            r_re <= 1'b0;
            r_rs <= 1'b0;
        end else begin
            r_rc <= n_rc;
            r_re <= n_re;
            r_rs <= n_rs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ch   <= i_bundle.ch;
            r_stat <= i_bundle.stat;
        end
    end

    assign o_event_kind  = r_rc ? KIND_CHAR : (r_re ? KIND_END : KIND_STAT);
    assign o_out_char    = r_rc ? r_ch : '0;
    assign o_line_status = (!r_rc && !r_re && r_rs) ? r_stat : ST_OK;
    assign o_last_of_run = (r_rc && !r_re && !r_rs) || (!r_rc && r_re && !r_rs)
                        || (!r_rc && !r_re && r_rs);

endmodule

`default_nettype wire

### design/qat_checker.sv
`default_nettype none

module qat_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_pop,
    input wire logic                       o_empty,
    input wire logic [1:0]                 o_event_kind,
    input wire logic [qat_pkg::CHAR_W-1:0] o_out_char,
    input wire logic [1:0]                 o_line_status,
    input wire logic                       o_last_of_run
);
    import qat_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_event_kind == KIND_STAT) |-> o_last_of_run)
        else $error("line status is not the last result of its character");

    a_fields_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_event_kind != KIND_STAT)
            |-> (o_line_status == ST_OK && o_event_kind != 2'd3))
        else $error("status field set on a non-status result");

    a_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_event_kind != KIND_CHAR) |-> o_out_char == '0)
        else $error("character field set on a non-character result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_event_kind)
            && $stable(o_out_char) && $stable(o_line_status)))
        else $error("stalled result changed");

endmodule

bind quoted_argument_tokenizer_core qat_checker u_qat_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_pop         (i_pop),
    .o_empty       (o_empty),
    .o_event_kind  (o_event_kind),
    .o_out_char    (o_out_char),
    .o_line_status (o_line_status),
    .o_last_of_run (o_last_of_run)
);

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import qat_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 260;
    localparam int HOLD_CYCLES = 40;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CHAR_W-1:0] ch;
        logic [1:0]        stat;
        logic              last;
    } t_tok_event;

    // Line tokenizer predictor plus the queue of events still owed by the block.
    class token_scoreboard;
        t_phase     ph;
        bit         in_quote;
        bit         after_space;
        bit         tok_nonempty;
        bit         last_space;
        bit         skipping;
        t_tok_event step_q[$];
        t_tok_event expected_events[$];
        int         mismatches;

        function new();
            clear_line();
            mismatches = 0;
        endfunction

        function void clear_line();
            ph = PH_NORMAL;
            in_quote = 1'b0;
            after_space = 1'b1;
            tok_nonempty = 1'b0;
            last_space = 1'b0;
            skipping = 1'b0;
        endfunction

        function void post(logic [1:0] kind, logic [CHAR_W-1:0] ch, logic [1:0] stat);
            t_tok_event e;
            e.kind = kind;
            e.ch = ch;
            e.stat = stat;
            e.last = 1'b0;
            step_q.insert(step_q.size(), e);
        endfunction

        function void add_char(logic [CHAR_W-1:0] ch);
            post(KIND_CHAR, ch, ST_OK);
            tok_nonempty = 1'b1;
            last_space = (ch == CH_SPACE);
        endfunction

        function void close_token();
            post(KIND_END, '0, ST_OK);
            tok_nonempty = 1'b0;
            last_space = 1'b0;
        endfunction

        function void misplaced(bit at_end);
            post(KIND_STAT, '0, ST_MISPLACED);
            if (at_end) begin
                clear_line();
            end else begin
                skipping = 1'b1;
            end
        endfunction

        function void note_char(logic [CHAR_W-1:0] ch, bit at_end);
            logic [1:0] stat;
            bit         stop;
            stop = 1'b0;
            step_q.delete();
            // drop everything after an error until the line ends
            if (skipping) begin
                if (at_end) clear_line();
                return;
            end
            case (ph)
                PH_ESCAPE: begin
                    if (ch == CH_BSLASH || ch == CH_QUOTE || ch == CH_APOS) add_char(ch);
                    ph = PH_NORMAL;
                end
                PH_CLOSE: begin
                    if (ch != CH_SPACE) begin
                        misplaced(at_end);
                        stop = 1'b1;
                    end else begin
                        close_token();
                        ph = PH_NORMAL;
                    end
                end
                default: begin
                    if (ch == CH_BSLASH) begin
                        if (!at_end) ph = PH_ESCAPE;
                    end else if (ch == CH_QUOTE) begin
                        if (in_quote) begin
                            in_quote = 1'b0;
                            if (at_end) close_token();
                            else ph = PH_CLOSE;
                        end else if (!after_space) begin
                            misplaced(at_end);
                            stop = 1'b1;
                        end else begin
                            in_quote = 1'b1;
                        end
                    end else if (ch == CH_SPACE) begin
                        if (in_quote) begin
                            if (!last_space) add_char(ch);
                        end else begin
                            close_token();
                        end
                    end else begin
                        add_char(ch);
                    end
                end
            endcase
            if (!stop) begin
                after_space = (ch == CH_SPACE);
                if (at_end) begin
                    stat = in_quote ? ST_UNTERM : ST_OK;
                    if (tok_nonempty || in_quote) close_token();
                    post(KIND_STAT, '0, stat);
                    clear_line();
                end
            end
            if (step_q.size() > 0) step_q[$].last = 1'b1;
            foreach (step_q[i]) expected_events.insert(expected_events.size(), step_q[i]);
        endfunction

        function string show(t_tok_event e);
            return $sformatf("kind=%0d char=%h status=%0d last=%0b",
                             e.kind, e.ch, e.stat, e.last);
        endfunction

        function void flag(string what, t_tok_event want, t_tok_event got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s: expected %s, got %s",
                         $time, what, show(want), show(got));
        endfunction

        function void check_event(logic [1:0] kind, logic [CHAR_W-1:0] ch, logic [1:0] stat,
                                  logic last);
            t_tok_event got;
            t_tok_event want;
            got.kind = kind;
            got.ch = ch;
            got.stat = stat;
            got.last = last;
            if (expected_events.size() == 0) begin
                flag("unexpected result", '0, got);
                return;
            end
            want = expected_events.pop_front();
            if (got.kind !== want.kind || got.ch !== want.ch || got.stat !== want.stat ||
                got.last !== want.last)
                flag("mismatch", want, got);
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_push;
    logic              o_full;
    logic [CHAR_W-1:0] i_char_code;
    logic              i_line_end;
    logic              i_pop;
    logic              o_empty;
    logic [1:0]        o_event_kind;
    logic [CHAR_W-1:0] o_out_char;
    logic [1:0]        o_line_status;
    logic              o_last_of_run;

    token_scoreboard   sb = new();
    logic [CHAR_W-1:0] line_buf[$];
    int                n_sent = 0;
    int                n_recv = 0;
    bit                hold_req = 1'b0;
    int unsigned       cycles = 0;

    quoted_argument_tokenizer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_char_code   (i_char_code),
        .i_line_end    (i_line_end),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_event_kind  (o_event_kind),
        .o_out_char    (o_out_char),
        .o_line_status (o_line_status),
        .o_last_of_run (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void line_add(input logic [CHAR_W-1:0] ch);
        line_buf.insert(line_buf.size(), ch);
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic at_end);
        int gap;
        // every third stretch of 40 items goes without gaps
        gap = (((n_sent / 40) % 3) == 2) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_char_code <= ch;
        i_line_end <= at_end;
        do @(posedge i_clk); while (o_full);
        sb.note_char(ch, at_end);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
    endtask

    task automatic send_text(input string s);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++) line_add(CHAR_W'(s[i]));
        send_line();
    endtask

    function automatic logic [CHAR_W-1:0] pick_plain();
        if ($urandom_range(0, 7) == 0) return CHAR_W'($urandom_range(128, 21'h1FFFFF));
        return CHAR_W'($urandom_range("a", "z"));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_escaped();
        case ($urandom_range(0, 3))
            0: return CH_BSLASH;
            1: return CH_QUOTE;
            2: return CH_APOS;
            default: return pick_plain();
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_noise();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_QUOTE;
            2: return CH_BSLASH;
            3: return CH_APOS;
            default: return pick_plain();
        endcase
    endfunction

    // plain and quoted words separated by spaces, with escapes mixed in
    function automatic void build_words();
        int n_words;
        int n_len;
        bit quoted;
        line_buf.delete();
        n_words = $urandom_range(1, 4);
        for (int w = 0; w < n_words; w++) begin
            if (w > 0) repeat ($urandom_range(1, 2)) line_add(CH_SPACE);
            quoted = ($urandom_range(0, 2) == 0);
            if (quoted) line_add(CH_QUOTE);
            n_len = $urandom_range(quoted ? 0 : 1, 4);
            for (int k = 0; k < n_len; k++) begin
                case ($urandom_range(0, 5))
                    0: begin
                        line_add(CH_BSLASH);
                        line_add(pick_escaped());
                    end
                    1: begin
                        if (quoted) repeat ($urandom_range(1, 3)) line_add(CH_SPACE);
                        else line_add(pick_plain());
                    end
                    default: line_add(pick_plain());
                endcase
            end
            if (quoted) line_add(CH_QUOTE);
        end
    endfunction

    // result side: random stalls, gap-free stretches, and one long hold-off
    initial begin
        int gap;
        i_pop <= 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = (((n_recv / 50) % 3) == 1) ? 0 : $urandom_range(0, 6);
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                i_pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty);
            sb.check_event(o_event_kind, o_out_char, o_line_status, o_last_of_run);
            n_recv++;
            @(negedge i_clk);
        end
    end

    initial begin
        int  start_count;
        bit  hold_done;
        hold_done = 1'b0;
        i_rst_n <= 1'b0;
        i_push <= 1'b0;
        i_char_code <= '0;
        i_line_end <= 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_text("a  b");        // empty token between two spaces
        send_text("\"a  b\"");    // space collapse, close quote at line end
        send_text("\\\"\\q\\");   // kept escape, dropped escape, backslash at line end
        send_text("a\"b");        // misplaced opening quote, rest ignored
        send_text("\"a\"b");      // closing quote not followed by space
        send_text("\"a");         // unterminated quote
        line_buf.delete();
        line_add('0);
        line_add({CHAR_W{1'b1}});
        send_line();

        start_count = n_sent;
        while (n_sent < start_count + RANDOM_ITEMS) begin
            if (!hold_done && n_sent >= start_count + 80) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 3) != 0) begin
                build_words();
                if ($urandom_range(0, 4) == 0)
                    line_buf[$urandom_range(0, line_buf.size() - 1)] = pick_noise();
            end else begin
                line_buf.delete();
                repeat ($urandom_range(1, 8)) line_add(pick_noise());
            end
            send_line();
        end
        i_push <= 1'b0;

        while (sb.expected_events.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_events.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
